/* rtl/lmtc_pkg.sv */
// shared types and constants of the lcd mode timing controller
`default_nettype none
package lmtc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    // register offsets
    localparam logic [3:0] REG_CONTROL = 4'd0;
    localparam logic [3:0] REG_STATUS  = 4'd1;
    localparam logic [3:0] REG_SCY     = 4'd2;
    localparam logic [3:0] REG_SCX     = 4'd3;
    localparam logic [3:0] REG_LINE    = 4'd4;
    localparam logic [3:0] REG_LYC     = 4'd5;
    localparam logic [3:0] REG_DMA     = 4'd6;
    localparam logic [3:0] REG_BGP     = 4'd7;
    localparam logic [3:0] REG_OBP0    = 4'd8;
    localparam logic [3:0] REG_OBP1    = 4'd9;
    localparam logic [3:0] REG_WY      = 4'd10;
    localparam logic [3:0] REG_WX      = 4'd11;

    localparam logic [9:0] DOTS_OAM    = 10'd80;
    localparam logic [9:0] DOTS_XFER   = 10'd172;
    localparam logic [9:0] DOTS_HBLANK = 10'd204;
    localparam logic [9:0] DOTS_LINE   = 10'd456;

    localparam logic [6:0] CYCLES_MAX  = 7'd80;

    localparam logic [7:0] LINE_VBLANK = 8'd144;
    localparam logic [7:0] LINE_WRAP   = 8'd154;
    localparam logic [7:0] LINE_LAST   = 8'd153;
    localparam logic [7:0] LINE_RESET  = 8'd145;

    localparam logic [7:0] CONTROL_RESET = 8'h91;
    localparam logic [7:0] BGP_RESET     = 8'hFC;
    localparam logic [7:0] OBP_RESET     = 8'hFF;
    localparam logic [7:0] DMA_READ      = 8'hFF;

    typedef struct packed {
        t_cmd       cmd;
        logic [6:0] cycles;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank_request;
        logic       stat_request;
        logic       render_line;
        logic [7:0] line_number;
    } t_out_word;

endpackage
`default_nettype wire

/* rtl/lmtc_core.sv */
// register file, dot clock and line sequencer, with all state updated on each fired word
`default_nettype none
module lmtc_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  wire lmtc_pkg::t_in_word i_item,
    output lmtc_pkg::t_out_word o_result
);
    import lmtc_pkg::*;

    logic [7:0] r_control, n_control;
    logic [4:0] r_stat_hi, n_stat_hi;     // status bits 7..3
    logic       r_lyc_flag, n_lyc_flag;
    t_mode      r_mode, n_mode;
    logic [7:0] r_line, n_line;
    logic [7:0] r_lyc, n_lyc;
    logic [9:0] r_dot, n_dot;
    logic [7:0] r_scy, n_scy, r_scx, n_scx, r_bgp, n_bgp;
    logic [7:0] r_obp0, n_obp0, r_obp1, n_obp1, r_wy, n_wy, r_wx, n_wx;

    logic [6:0] cyc;
    logic [9:0] dot_sum;
    logic [7:0] line_inc;
    logic       vbl, stat, render;
    logic [7:0] rd;

    always_comb begin
        n_control  = r_control;
        n_stat_hi  = r_stat_hi;
        n_lyc_flag = r_lyc_flag;
        n_mode     = r_mode;
        n_line     = r_line;
        n_lyc      = r_lyc;
        n_dot      = r_dot;
        n_scy = r_scy; n_scx = r_scx; n_bgp = r_bgp;
        n_obp0 = r_obp0; n_obp1 = r_obp1; n_wy = r_wy; n_wx = r_wx;
        vbl    = 1'b0;
        stat   = 1'b0;
        render = 1'b0;
        rd     = 8'd0;
        cyc      = (i_item.cycles > CYCLES_MAX) ? CYCLES_MAX : i_item.cycles;
        dot_sum  = r_dot + {3'd0, cyc};
        line_inc = r_line + 8'd1;

        case (i_item.cmd)
            CMD_TICK: begin
                if (r_control[7]) begin
                    n_dot = dot_sum;
                    case (r_mode)
                        MODE_HBLANK: begin
                            if (dot_sum >= DOTS_HBLANK) begin
                                n_dot  = dot_sum - DOTS_HBLANK;
                                n_line = line_inc;
                                if (line_inc == LINE_VBLANK) begin
                                    vbl    = 1'b1;
                                    n_mode = MODE_VBLANK;
                                    stat   = r_stat_hi[1];
                                end else begin
                                    n_mode = MODE_OAM;
                                    stat   = r_stat_hi[2];
                                end
                            end
                        end
                        MODE_VBLANK: begin
                            if (dot_sum >= DOTS_LINE) begin
                                n_dot  = dot_sum - DOTS_LINE;
                                n_line = line_inc;
                                if (line_inc == LINE_WRAP) begin
                                    n_line = 8'd0;
                                    n_mode = MODE_OAM;
                                    stat   = r_stat_hi[2];
                                end
                            end
                        end
                        MODE_OAM: begin
                            if (dot_sum >= DOTS_OAM) begin
                                n_dot  = dot_sum - DOTS_OAM;
                                n_mode = MODE_XFER;
                            end
                        end
                        default: begin
                            if (dot_sum >= DOTS_XFER) begin
                                n_dot  = dot_sum - DOTS_XFER;
                                render = 1'b1;
                                n_mode = MODE_HBLANK;
                                stat   = r_stat_hi[0];
                            end
                        end
                    endcase
                    // compare flag is level sensitive, request needs its enable
                    n_lyc_flag = (r_lyc == n_line);
                    if (n_lyc_flag && r_stat_hi[3]) begin
                        stat = 1'b1;
                    end
                end
            end
            CMD_WRITE: begin
                case (i_item.reg_offset)
                    REG_CONTROL: begin
                        n_control = i_item.write_data;
                        if (r_control[7] && !i_item.write_data[7]) begin
                            n_line = LINE_LAST;
                            n_dot  = DOTS_LINE;
                            n_mode = MODE_VBLANK;
                        end
                    end
                    REG_STATUS: n_stat_hi = i_item.write_data[7:3];
                    REG_LINE:   n_line = 8'd0;
                    REG_LYC:    n_lyc = i_item.write_data;
                    REG_SCY:    n_scy = i_item.write_data;
                    REG_SCX:    n_scx = i_item.write_data;
                    REG_BGP:    n_bgp = i_item.write_data;
                    REG_OBP0:   n_obp0 = i_item.write_data;
                    REG_OBP1:   n_obp1 = i_item.write_data;
                    REG_WY:     n_wy = i_item.write_data;
                    REG_WX:     n_wx = i_item.write_data;
                    default: ;
                endcase
            end
            CMD_READ: begin
                case (i_item.reg_offset)
                    REG_CONTROL: rd = r_control;
                    REG_STATUS:  rd = {r_stat_hi, r_lyc_flag, r_mode};
                    REG_LINE:    rd = r_line;
                    REG_LYC:     rd = r_lyc;
                    REG_DMA:     rd = DMA_READ;
                    REG_SCY:     rd = r_scy;
                    REG_SCX:     rd = r_scx;
                    REG_BGP:     rd = r_bgp;
                    REG_OBP0:    rd = r_obp0;
                    REG_OBP1:    rd = r_obp1;
                    REG_WY:      rd = r_wy;
                    REG_WX:      rd = r_wx;
                    default:     rd = 8'd0;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.read_data      = rd;
        o_result.vblank_request = vbl;
        o_result.stat_request   = stat;
        o_result.render_line    = render;
        o_result.line_number    = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control  <= CONTROL_RESET;
            r_stat_hi  <= 5'd0;
            r_lyc_flag <= 1'b0;
            r_mode     <= MODE_VBLANK;
            r_line     <= LINE_RESET;
            r_lyc      <= 8'd0;
            r_dot      <= DOTS_LINE;
            r_scy      <= 8'd0;
            r_scx      <= 8'd0;
            r_bgp      <= BGP_RESET;
            r_obp0     <= OBP_RESET;
            r_obp1     <= OBP_RESET;
            r_wy       <= 8'd0;
            r_wx       <= 8'd0;
        end else if (i_fire) begin
            r_control  <= n_control;
            r_stat_hi  <= n_stat_hi;
            r_lyc_flag <= n_lyc_flag;
            r_mode     <= n_mode;
            r_line     <= n_line;
            r_lyc      <= n_lyc;
            r_dot      <= n_dot;
            r_scy      <= n_scy;
            r_scx      <= n_scx;
            r_bgp      <= n_bgp;
            r_obp0     <= n_obp0;
            r_obp1     <= n_obp1;
            r_wy       <= n_wy;
            r_wx       <= n_wx;
        end
    end

endmodule
`default_nettype wire

/* rtl/lcd_mode_timing_controller.sv */
// top level: input register, timing core and output register of the lcd mode controller
//
// channel | dir | handshake          | word
// input   | in  | i_valid / o_stall  | i_data  (cmd, cycles, reg_offset, write_data)
// output  | out | o_valid / i_stall  | o_data  (read_data, requests, line_number)
//
// one word per cycle unless the output stalls; results leave via the output register
// the core updates all state as a word fires from input to output register
// reset is synchronous and restores the register file and timing state
// a stalled output holds its word; the input register takes one more word meanwhile
`default_nettype none
module lcd_mode_timing_controller (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire lmtc_pkg::t_in_word i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output lmtc_pkg::t_out_word o_data
);
    import lmtc_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word result;
    logic      out_free;
    logic      fire;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    lmtc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    // input side only stalls behind a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked output");

    // vblank request only on the word that reaches line 144
    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.vblank_request) |-> (o_data.line_number == LINE_VBLANK))
        else $error("vblank request off line 144");

    // render pulse and vblank entry come from different mode transitions
    a_render_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.render_line) |-> !o_data.vblank_request)
        else $error("render and vblank on one word");

endmodule
`default_nettype wire
